>>> sv/vst_pkg.sv
package vst_pkg;

  // default fraction bits of the fixed-point format
  localparam int unsigned FRAC_BITS_DEF = 16;

  // shared multiplier operand and product widths
  localparam int unsigned OPW = 34;
  localparam int unsigned PRW = 2 * OPW;

  // item kinds carried in the input tuser
  localparam logic [1:0] MODE_LOAD_MV   = 2'd0;
  localparam logic [1:0] MODE_LOAD_PROJ = 2'd1;
  localparam logic [1:0] MODE_XFORM     = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_BOTTOM = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_NEAR   = 3'd4;
  localparam logic [2:0] REG_FAR    = 3'd5;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] bottom;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [16:0]        near;
    logic [16:0]        far;
  } vst_cfg_t;

  typedef struct packed {
    logic signed [31:0] vw;
    logic signed [31:0] vz;
    logic signed [31:0] vy;
    logic signed [31:0] vx;
    logic signed [31:0] elem_val;
    logic [3:0]         elem_idx;
  } vst_in_t;

  typedef struct packed {
    logic        fault;
    logic [31:0] rhw;
    logic [31:0] sd;
    logic [31:0] sy;
    logic [31:0] sx;
  } vst_res_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic clear;
    logic shift_one;
  } vst_mac_ctrl_t;

  // saturate a wide signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [PRW-1:0] v);
    logic fits;
    fits = (&v[PRW-1:31]) | ~(|v[PRW-1:31]);
    if (fits) begin
      sat32 = v[31:0];
    end else begin
      sat32 = v[PRW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  endfunction

endpackage

>>> sv/vertex_to_screen_transform_top.sv
// vertex to screen transform
// input stream: tuser carries the item kind (load modelview element, load
// projection element, transform vertex); tdata carries index, value and the
// object vertex. loads update a matrix and give no transfer out.
// a transform item forms projection times modelview (64 multiply-adds),
// multiplies the vertex (16), takes 1/w with a restoring divider
// (2*FRAC_BITS+1 quotient bits), normalizes (3) and maps to the viewport (3).
// every multiply-add runs on the single shared multiplier; values are Q16.16
// at the default FRAC_BITS. a zero clip w skips the divide and returns a
// fault result with zero outputs. the block takes one item at a time and
// stays not ready while a transform runs.
// output stream: one transfer per transform; a result register holds it, so
// the next item is taken while the receiver stalls, and a finished transform
// waits until the register is free.
// reset loads identity into both matrices and the viewport reset values.
// the user writes configuration registers over the apb port only while idle;
// the block itself does not enforce this.
module vertex_to_screen_transform_top
  import vst_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // apb configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // element_index, element_value, vertex_x, vertex_y, vertex_z, vertex_w, zero fill
  input  logic [167:0] s_axis_tdata,
  // mode
  input  logic [1:0]   s_axis_tuser,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // screen_x, screen_y, screen_depth, recip_w
  output logic [127:0] m_axis_tdata,
  // divide_fault
  output logic [0:0]   m_axis_tuser
);

  vst_cfg_t   cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;

  vst_in_t  in_item;
  vst_res_t core_res, out_q;
  logic     core_valid, core_ready;
  logic     out_valid_q;

  // apb register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left   <= '0;
      cfg_q.bottom <= '0;
      cfg_q.width  <= 15'd1024;
      cfg_q.height <= 15'd768;
      cfg_q.near   <= '0;
      cfg_q.far    <= 17'h1_0000;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LEFT:   cfg_q.left   <= pwdata[15:0];
        REG_BOTTOM: cfg_q.bottom <= pwdata[15:0];
        REG_WIDTH:  cfg_q.width  <= pwdata[14:0];
        REG_HEIGHT: cfg_q.height <= pwdata[14:0];
        REG_NEAR:   cfg_q.near   <= pwdata[16:0];
        REG_FAR:    cfg_q.far    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEFT:   prdata = {{16{cfg_q.left[15]}}, cfg_q.left};
      REG_BOTTOM: prdata = {{16{cfg_q.bottom[15]}}, cfg_q.bottom};
      REG_WIDTH:  prdata = 32'(cfg_q.width);
      REG_HEIGHT: prdata = 32'(cfg_q.height);
      REG_NEAR:   prdata = 32'(cfg_q.near);
      REG_FAR:    prdata = 32'(cfg_q.far);
      default:    prdata = '0;
    endcase
  end

  // unpack input transfer
  assign in_item = s_axis_tdata[163:0];

  vst_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_mode_i  (s_axis_tuser),
    .in_item_i  (in_item),
    .res_valid_o(core_valid),
    .res_ready_i(core_ready),
    .res_o      (core_res)
  );

  // result register
  assign core_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_valid && core_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_valid && core_ready) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.rhw, out_q.sd, out_q.sy, out_q.sx};
  assign m_axis_tuser  = out_q.fault;

endmodule

>>> sv/vst_mac.sv
module vst_mac
  import vst_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vst_mac_ctrl_t         ctrl_i,
  input  logic signed [OPW-1:0] a_i,
  input  logic signed [OPW-1:0] b_i,
  input  logic signed [PRW-1:0] init_i,
  output logic [31:0]           sum_sat_o
);

  logic signed [PRW-1:0] prod_q, prod_d;
  logic signed [PRW-1:0] acc_q, acc_d;
  logic signed [PRW-1:0] shifted;

  // product stage
  assign prod_d = a_i * b_i;

  // floor shift then accumulate onto a cleared or preset sum
  assign shifted = ctrl_i.shift_one ? (prod_q >>> 1) : (prod_q >>> FRAC_BITS);
  assign acc_d   = (ctrl_i.clear ? init_i : acc_q) + shifted;
  assign sum_sat_o = sat32(acc_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

endmodule

>>> sv/vst_recip.sv
module vst_recip
  import vst_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned QW = 2 * FRAC_BITS + 1,
  localparam int unsigned CW = $clog2(QW)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   mag_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   mag_q;
  logic [32:0]   rem_q, rem_sh;
  logic [QW-1:0] quot_q;
  logic          ge;

  // one quotient bit a cycle; the dividend is a single one at its top bit
  assign rem_sh = {rem_q[31:0], (cnt_q == '0)};
  assign ge     = rem_sh >= {1'b0, mag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q  <= mag_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? (rem_sh - {1'b0, mag_q}) : rem_sh;
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> sv/vst_core.sv
module vst_core
  import vst_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  vst_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic [1:0] in_mode_i,
  input  vst_in_t  in_item_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output vst_res_t res_o
);

  localparam int unsigned QW = 2 * FRAC_BITS + 1;
  localparam logic [31:0] ONE32 = 32'(1) << FRAC_BITS;
  localparam logic signed [OPW-1:0] ONE_OP = OPW'(1) << FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAT  = 3'd1;
  localparam logic [2:0] S_VEC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_NRM  = 3'd4;
  localparam logic [2:0] S_VP   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q;
  logic [5:0] cnt_q;
  logic       ph_q;
  logic       started_q;

  logic [31:0] mv_q [16];
  logic [31:0] pj_q [16];
  logic [31:0] t_q [16];
  logic [31:0] v_q [4];
  logic [31:0] clip_q [4];
  logic [31:0] n_q [3];
  logic [31:0] rhw_q;
  vst_res_t    res_q;

  vst_mac_ctrl_t         ctrl;
  logic signed [OPW-1:0] op_a, op_b;
  logic signed [PRW-1:0] op_init;
  logic [31:0]           sum_sat;

  logic          div_start;
  logic          div_done;
  logic [QW-1:0] quot;
  logic [31:0]   mag;
  logic [63:0]   q64;
  logic [31:0]   rhw_d;

  logic [3:0] mat_e;
  logic [1:0] mat_i, vec_r, vec_c;

  assign mat_e = cnt_q[5:2];
  assign mat_i = cnt_q[1:0];
  assign vec_r = cnt_q[3:2];
  assign vec_c = cnt_q[1:0];

  function automatic logic signed [OPW-1:0] sx34(input logic [31:0] v);
    sx34 = {{(OPW - 32){v[31]}}, v};
  endfunction

  // operand selection for the shared unit
  always_comb begin
    ctrl    = '0;
    op_a    = '0;
    op_b    = '0;
    op_init = '0;
    ctrl.mul_en = ~ph_q;
    ctrl.acc_en = ph_q;
    unique case (state_q)
      S_MAT: begin
        op_a = sx34(pj_q[{mat_i, mat_e[1:0]}]);
        op_b = sx34(mv_q[{mat_e[3:2], mat_i}]);
        ctrl.clear = (mat_i == 2'd0);
      end
      S_VEC: begin
        op_a = sx34(t_q[{vec_c, vec_r}]);
        op_b = sx34(v_q[vec_c]);
        ctrl.clear = (vec_c == 2'd0);
      end
      S_NRM: begin
        op_a = sx34(clip_q[cnt_q[1:0]]);
        op_b = sx34(rhw_q);
        ctrl.clear = 1'b1;
      end
      S_VP: begin
        ctrl.clear = 1'b1;
        if (cnt_q[1:0] == 2'd0) begin
          op_a = ONE_OP + sx34(n_q[0]);
          op_b = OPW'(cfg_i.width);
          op_init = PRW'(cfg_i.left) <<< FRAC_BITS;
          ctrl.shift_one = 1'b1;
        end else if (cnt_q[1:0] == 2'd1) begin
          op_a = ONE_OP - sx34(n_q[1]);
          op_b = OPW'(cfg_i.height);
          op_init = PRW'(cfg_i.bottom) <<< FRAC_BITS;
          ctrl.shift_one = 1'b1;
        end else begin
          op_a = sx34(n_q[2]);
          op_b = OPW'(cfg_i.far) - OPW'(cfg_i.near);
          op_init = PRW'(cfg_i.near);
        end
      end
      default: begin
        ctrl.mul_en = 1'b0;
        ctrl.acc_en = 1'b0;
      end
    endcase
  end

  vst_mac #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk_i,
    .rst_ni,
    .ctrl_i   (ctrl),
    .a_i      (op_a),
    .b_i      (op_b),
    .init_i   (op_init),
    .sum_sat_o(sum_sat)
  );

  // reciprocal of clip w magnitude
  assign mag       = clip_q[3][31] ? (~clip_q[3] + 32'd1) : clip_q[3];
  assign div_start = (state_q == S_DIV) && !started_q;

  vst_recip #(
    .FRAC_BITS(FRAC_BITS)
  ) u_recip (
    .clk_i,
    .rst_ni,
    .start_i(div_start),
    .mag_i  (mag),
    .done_o (div_done),
    .quot_o (quot)
  );

  // signed saturation of the quotient
  assign q64 = 64'(quot);
  always_comb begin
    if (!clip_q[3][31]) begin
      rhw_d = (q64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q64[31:0];
    end else begin
      rhw_d = (q64 > 64'h8000_0000) ? 32'h8000_0000 : (~q64[31:0] + 32'd1);
    end
  end

  // sequencer and matrix stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      ph_q      <= 1'b0;
      started_q <= 1'b0;
      for (int k = 0; k < 16; k++) begin
        mv_q[k] <= (k % 5 == 0) ? ONE32 : 32'd0;
        pj_q[k] <= (k % 5 == 0) ? ONE32 : 32'd0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_mode_i == MODE_LOAD_MV) begin
              mv_q[in_item_i.elem_idx] <= in_item_i.elem_val;
            end else if (in_mode_i == MODE_LOAD_PROJ) begin
              pj_q[in_item_i.elem_idx] <= in_item_i.elem_val;
            end else if (in_mode_i == MODE_XFORM) begin
              state_q <= S_MAT;
              cnt_q   <= '0;
              ph_q    <= 1'b0;
            end
          end
        end
        S_MAT: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == 6'd63) begin
              state_q <= S_VEC;
            end
          end
        end
        S_VEC: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == 6'd15) begin
              cnt_q   <= '0;
              state_q <= (sum_sat == 32'd0) ? S_DONE : S_DIV;
            end
          end
        end
        S_DIV: begin
          started_q <= 1'b1;
          if (div_done) begin
            started_q <= 1'b0;
            state_q   <= S_NRM;
          end
        end
        S_NRM, S_VP: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == 6'd2) begin
              cnt_q   <= '0;
              state_q <= (state_q == S_NRM) ? S_VP : S_DONE;
            end
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && in_mode_i == MODE_XFORM) begin
      v_q[0] <= in_item_i.vx;
      v_q[1] <= in_item_i.vy;
      v_q[2] <= in_item_i.vz;
      v_q[3] <= in_item_i.vw;
    end
    if (state_q == S_MAT && ph_q && mat_i == 2'd3) begin
      t_q[mat_e] <= sum_sat;
    end
    if (state_q == S_VEC && ph_q && vec_c == 2'd3) begin
      clip_q[vec_r] <= sum_sat;
      if (vec_r == 2'd3 && sum_sat == 32'd0) begin
        res_q <= '{fault: 1'b1, default: '0};
      end
    end
    if (state_q == S_DIV && div_done) begin
      rhw_q     <= rhw_d;
      res_q.rhw <= rhw_d;
      res_q.fault <= 1'b0;
    end
    if (state_q == S_NRM && ph_q && cnt_q[1:0] != 2'd3) begin
      n_q[cnt_q[1:0]] <= sum_sat;
    end
    if (state_q == S_VP && ph_q) begin
      if (cnt_q[1:0] == 2'd0) begin
        res_q.sx <= sum_sat;
      end else if (cnt_q[1:0] == 2'd1) begin
        res_q.sy <= sum_sat;
      end else begin
        res_q.sd <= sum_sat;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

>>> tb/sv/vertex_to_screen_transform_top_tb.sv
module vertex_to_screen_transform_top_tb;
  import vst_pkg::*;

  localparam int FB = 16;
  localparam int XFORM_LATENCY = 260;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         mode;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] vw;
  } vtx_item_t;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sd;
    logic [31:0] rhw;
    logic        fault;
  } screen_res_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  // element_index, element_value, vertex_x, vertex_y, vertex_z, vertex_w, zero fill
  logic [167:0] s_axis_tdata = '0;
  // mode
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  // screen_x, screen_y, screen_depth, recip_w
  logic [127:0] m_axis_tdata;
  // divide_fault
  logic [0:0] m_axis_tuser;

  vertex_to_screen_transform_top dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // predictor state
  logic signed [31:0] mv_mat[16];
  logic signed [31:0] pj_mat[16];
  longint vp_left, vp_bottom, vp_width, vp_height, dp_near, dp_far;

  vtx_item_t   pending_items[$];
  screen_res_t expected_screen[$];
  int errors = 0;
  int n_xforms = 0, n_faults = 0, n_results = 0;
  bit stim_done = 0;
  bit hold_send = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return floor_shr(a * b, FB);
  endfunction

  function automatic longint reciprocal_w(longint w);
    longint unsigned mag, q;
    mag = (w < 0) ? -w : w;
    q = (64'd1 << (2 * FB)) / mag;
    if (w > 0) return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    if (q > (64'd1 << 31)) return -64'sd2147483648;
    return clamp32(-longint'(q));
  endfunction

  // apply one item to the predictor, returns 1 when a result is expected
  function automatic bit predict_screen(vtx_item_t it, output screen_res_t r);
    longint t[16];
    longint clip[4];
    longint vin[4];
    longint acc, rhw, nx, ny, nz, one;
    one = 64'sd1 << FB;
    r = '{default: 0};
    if (it.mode == MODE_LOAD_MV) begin
      mv_mat[it.idx] = it.val;
      return 0;
    end
    if (it.mode == MODE_LOAD_PROJ) begin
      pj_mat[it.idx] = it.val;
      return 0;
    end
    if (it.mode != MODE_XFORM) return 0;
    for (int rr = 0; rr < 4; rr++)
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int i = 0; i < 4; i++) acc += qmul(pj_mat[rr + i*4], mv_mat[i + c*4]);
        t[rr + c*4] = clamp32(acc);
      end
    vin[0] = it.vx; vin[1] = it.vy; vin[2] = it.vz; vin[3] = it.vw;
    for (int rr = 0; rr < 4; rr++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) acc += qmul(t[rr + c*4], vin[c]);
      clip[rr] = clamp32(acc);
    end
    if (clip[3] == 0) begin
      r.fault = 1;
      return 1;
    end
    rhw = reciprocal_w(clip[3]);
    nx = clamp32(qmul(clip[0], rhw));
    ny = clamp32(qmul(clip[1], rhw));
    nz = clamp32(qmul(clip[2], rhw));
    r.sx = 32'(clamp32(floor_shr((one + nx) * vp_width, 1) + vp_left * one));
    r.sy = 32'(clamp32(floor_shr((one - ny) * vp_height, 1) + vp_bottom * one));
    r.sd = 32'(clamp32(qmul(nz, dp_far - dp_near) + dp_near));
    r.rhw = 32'(rhw);
    return 1;
  endfunction

  // driver: random gap before each transfer, predicts on acceptance
  int send_gap = 0;
  always @(posedge clk_i) begin
    screen_res_t r;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_screen(pending_items[0], r)) begin
          expected_screen.push_back(r);
          n_xforms++;
          if (r.fault) n_faults++;
        end
        void'(pending_items.pop_front());
        send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        s_axis_tvalid <= 0;
      end else if (!s_axis_tvalid && pending_items.size() > 0 && !hold_send) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else begin
          s_axis_tvalid <= 1;
          s_axis_tuser <= pending_items[0].mode;
          s_axis_tdata <= {4'h0, pending_items[0].vw, pending_items[0].vz,
                           pending_items[0].vy, pending_items[0].vx,
                           pending_items[0].val, pending_items[0].idx};
        end
      end
    end
  end

  // monitor: random stalls, compares each result transfer
  int recv_gap = 0;
  always @(posedge clk_i) begin
    screen_res_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_screen.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          e = expected_screen.pop_front();
          if (m_axis_tdata[31:0] !== e.sx) begin
            $error("screen_x exp %h got %h", e.sx, m_axis_tdata[31:0]); errors++;
          end
          if (m_axis_tdata[63:32] !== e.sy) begin
            $error("screen_y exp %h got %h", e.sy, m_axis_tdata[63:32]); errors++;
          end
          if (m_axis_tdata[95:64] !== e.sd) begin
            $error("screen_depth exp %h got %h", e.sd, m_axis_tdata[95:64]); errors++;
          end
          if (m_axis_tdata[127:96] !== e.rhw) begin
            $error("recip_w exp %h got %h", e.rhw, m_axis_tdata[127:96]); errors++;
          end
          if (m_axis_tuser[0] !== e.fault) begin
            $error("divide_fault exp %b got %b", e.fault, m_axis_tuser[0]); errors++;
          end
        end
        recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        m_axis_tready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= (recv_gap == 0);
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  task automatic apb_write(logic [2:0] reg_idx, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {reg_idx, 2'b00}; pwdata <= data;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (reg_idx)
      REG_LEFT:   vp_left   = longint'(signed'(data[15:0]));
      REG_BOTTOM: vp_bottom = longint'(signed'(data[15:0]));
      REG_WIDTH:  vp_width  = data[14:0];
      REG_HEIGHT: vp_height = data[14:0];
      REG_NEAR:   dp_near   = data[16:0];
      REG_FAR:    dp_far    = data[16:0];
      default: ;
    endcase
  endtask

  task automatic drain_block();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_screen.size() > 0)
      @(posedge clk_i);
    repeat (XFORM_LATENCY) @(posedge clk_i);
  endtask

  task automatic add_item(logic [1:0] m, logic [3:0] i, logic [31:0] v,
                          logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
    vtx_item_t it;
    it.mode = m; it.idx = i; it.val = v;
    it.vx = x; it.vy = y; it.vz = z; it.vw = w;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] rand_q(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // modest random loads of both matrices (full range if wild), then vertices
  task automatic queue_scene(int n_vtx, bit wild);
    for (int i = 0; i < 16; i++) begin
      if ($urandom_range(0, 3) != 0)
        add_item(MODE_LOAD_MV, 4'(i), wild ? $urandom() : rand_q(4 << FB), $urandom(),
                 $urandom(), $urandom(), $urandom());
      if ($urandom_range(0, 3) != 0)
        add_item(MODE_LOAD_PROJ, 4'(i), wild ? $urandom() : rand_q(4 << FB), $urandom(),
                 $urandom(), $urandom(), $urandom());
    end
    for (int k = 0; k < n_vtx; k++) begin
      case ($urandom_range(0, 9))
        0: add_item(MODE_UNUSED, 4'($urandom()), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom());
        1: add_item(MODE_XFORM, 4'($urandom()), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom());
        2: add_item(MODE_XFORM, 4'($urandom()), $urandom(), rand_q(100 << FB),
                    rand_q(100 << FB), rand_q(100 << FB), 32'd0);
        default: add_item(MODE_XFORM, 4'($urandom()), $urandom(), rand_q(100 << FB),
                          rand_q(100 << FB), rand_q(100 << FB), rand_q(4 << FB));
      endcase
    end
  endtask

  task automatic random_cfg();
    apb_write(REG_LEFT, $urandom());
    apb_write(REG_BOTTOM, $urandom());
    apb_write(REG_WIDTH, $urandom_range(0, 32767));
    apb_write(REG_HEIGHT, $urandom_range(0, 32767));
    apb_write(REG_NEAR, $urandom_range(0, 65536));
    apb_write(REG_FAR, $urandom_range(0, 65536));
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      mv_mat[i] = (i % 5 == 0) ? 32'sh10000 : 0;
      pj_mat[i] = mv_mat[i];
    end
    vp_left = 0; vp_bottom = 0; vp_width = 1024; vp_height = 768;
    dp_near = 0; dp_far = 65536;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;

    // directed: identity transforms, extremes, zero w, ignored mode, loads
    add_item(MODE_XFORM, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
    add_item(MODE_XFORM, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h1);
    add_item(MODE_XFORM, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    add_item(MODE_XFORM, 0, 0, 32'h8000, 32'h8000, 32'h8000, 32'h0);
    add_item(MODE_XFORM, 0, 0, 0, 0, 0, 32'h80000000);
    add_item(MODE_XFORM, 0, 0, 32'hFFFF8000, 32'h4000, 32'h2000, 32'h7FFFFFFF);
    add_item(MODE_UNUSED, 4'hF, 32'hFFFFFFFF, '1, '1, '1, '1);
    add_item(MODE_LOAD_MV, 4'hF, 32'h7FFFFFFF, 0, 0, 0, 0);
    add_item(MODE_LOAD_PROJ, 4'h0, 32'h80000000, 0, 0, 0, 0);
    add_item(MODE_XFORM, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
    add_item(MODE_LOAD_MV, 4'hF, 32'h10000, 0, 0, 0, 0);
    add_item(MODE_LOAD_PROJ, 4'h0, 32'h10000, 0, 0, 0, 0);
    add_item(MODE_LOAD_PROJ, 4'hA, 32'h0, 0, 0, 0, 0);
    add_item(MODE_XFORM, 0, 0, 32'h20000, 32'h30000, 32'h40000, 32'h20000);
    drain_block();

    // extreme configuration
    apb_write(REG_LEFT, 32'h8000);
    apb_write(REG_BOTTOM, 32'h7FFF);
    apb_write(REG_WIDTH, 32'h7FFF);
    apb_write(REG_HEIGHT, 0);
    apb_write(REG_NEAR, 32'h10000);
    apb_write(REG_FAR, 0);
    queue_scene(30, 0);
    queue_scene(10, 1);
    drain_block();

    // pause the sender mid-scene until every expected result has come
    queue_scene(20, 0);
    repeat (600) @(posedge clk_i);
    hold_send <= 1;
    @(posedge clk_i);
    while (s_axis_tvalid || expected_screen.size() > 0) @(posedge clk_i);
    hold_send <= 0;
    drain_block();

    for (int ph = 0; ph < 6; ph++) begin
      random_cfg();
      for (int s = 0; s < 8; s++) queue_scene(15, s == 7);
      drain_block();
    end

    $display("covered %0d transforms (%0d with zero clip w) over 8 viewport settings",
             n_xforms, n_faults);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
sv/vst_pkg.sv
sv/vst_mac.sv
sv/vst_recip.sv
sv/vst_core.sv
sv/vertex_to_screen_transform_top.sv
tb/sv/vertex_to_screen_transform_top_tb.sv
